// ===== src/rvpt_pkg.sv =====
// Package with shared widths, register indexes and the setup status struct.
package rvpt_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned MatW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumEntries = 9;

  localparam logic [CfgIdxW-1:0] RegShiftX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegShiftY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegShiftZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRotX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRotY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRotZ = 3'd5;

  localparam logic [MatW-1:0] OneQ30 = 32'h4000_0000;

  typedef logic signed [MatW-1:0] mat_t [NumEntries];

  typedef struct packed {
    logic start;
    logic busy;
  } setup_ctl_t;
endpackage

// ===== src/rvpt_divider.sv =====
// Restoring divider that produces a rounded and a truncated quotient, one bit per cycle.
module rvpt_divider
  import rvpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [95:0] num_i,
  input  logic [63:0] den_i,
  input  logic [6:0]  bits_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [63:0] floor_o
);
  logic [96:0] rem_q, rem_d;
  logic [95:0] num_q, num_d;
  logic [63:0] den_q;
  logic [63:0] quo_q, quo_d;
  logic [6:0]  cnt_q;
  logic        run_q;
  logic [96:0] trial;

  assign trial = {rem_q[95:0], num_q[95]};
  always_comb begin
    num_d = {num_q[94:0], 1'b0};
    if (trial >= {33'd0, den_q}) begin
      rem_d = trial - {33'd0, den_q};
      quo_d = {quo_q[62:0], 1'b1};
    end else begin
      rem_d = trial;
      quo_d = {quo_q[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= bits_i;
      end else if (run_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          run_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= num_i << (7'd96 - bits_i);
      den_q <= den_i;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = (quo_q + 64'd1) >> 1;
  assign floor_o = quo_q;
endmodule

// ===== src/rvpt_setup.sv =====
// Sequencer that rebuilds the rotation matrix from the rotation vector.
module rvpt_setup
  import rvpt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DataW-1:0] rot_x_i,
  input  logic signed [DataW-1:0] rot_y_i,
  input  logic signed [DataW-1:0] rot_z_i,
  output setup_ctl_t              ctl_o,
  output mat_t                    mat_o
);
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSum  = 4'd1;
  localparam logic [3:0] StSqrt = 4'd2;
  localparam logic [3:0] StDivC = 4'd3;
  localparam logic [3:0] StDivU = 4'd4;
  localparam logic [3:0] StMul  = 4'd5;
  localparam logic [3:0] StDivT = 4'd6;
  localparam logic [3:0] StOut  = 4'd7;
  localparam logic [3:0] StWait = 4'd8;

  logic [3:0]  st_q;
  logic [1:0]  i_q, j_q;
  logic [63:0] s_q;
  logic [63:0] root_q, rem_q;
  logic [5:0]  sq_cnt_q;
  logic signed [63:0] c_q;
  logic signed [63:0] u_q [3];
  logic signed [63:0] t_q [3][3];
  logic signed [63:0] prod_q;
  logic [31:0] mag_a;
  logic signed [31:0] a_sel;
  logic [63:0] pair, rem_sh, trial_sq;
  logic [6:0]  sh_amt;
  logic        div_start_q, div_done;
  logic [95:0] div_num_q;
  logic [63:0] div_den_q;
  logic [6:0]  div_bits_q;
  logic [63:0] div_quot;
  logic [63:0] div_floor;
  logic        div_wait_q;
  logic [63:0] pmag;
  mat_t        mat_q;

  always_comb begin
    unique case (i_q)
      2'd0: a_sel = rot_x_i;
      2'd1: a_sel = rot_y_i;
      default: a_sel = rot_z_i;
    endcase
  end
  assign mag_a = a_sel[31] ? 32'(-a_sel) : a_sel;
  assign sh_amt = 7'(2 * (sq_cnt_q - 6'd16));
  assign pair = (sq_cnt_q >= 6'd16) ? ((s_q >> sh_amt) & 64'd3) : 64'd0;
  assign rem_sh = (rem_q << 2) | pair;
  assign trial_sq = (root_q << 2) | 64'd1;
  assign pmag = prod_q[63] ? 64'(-prod_q) : prod_q;

  rvpt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .bits_i (div_bits_q),
    .done_o (div_done),
    .quot_o (div_quot),
    .floor_o(div_floor)
  );

  function automatic logic signed [MatW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      div_start_q <= 1'b0;
      div_wait_q <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        mat_q[k] <= ((k % 4) == 0) ? OneQ30 : '0;
      end
    end else begin
      div_start_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (start_i) begin
            st_q <= StSum;
            s_q <= 64'h1_0000_0000;
            i_q <= 2'd0;
          end
        end
        StSum: begin
          s_q <= s_q + 64'(mag_a) * 64'(mag_a);
          if (i_q == 2'd2) begin
            st_q <= StSqrt;
            root_q <= '0;
            rem_q <= '0;
            sq_cnt_q <= 6'd47;
          end else begin
            i_q <= i_q + 2'd1;
          end
        end
        StSqrt: begin
          if (rem_sh >= trial_sq) begin
            rem_q <= rem_sh - trial_sq;
            root_q <= (root_q << 1) | 64'd1;
          end else begin
            rem_q <= rem_sh;
            root_q <= root_q << 1;
          end
          if (sq_cnt_q == 6'd0) begin
            st_q <= StDivC;
            div_wait_q <= 1'b0;
          end else begin
            sq_cnt_q <= sq_cnt_q - 6'd1;
          end
        end
        StDivC: begin
          if (!div_wait_q) begin
            div_start_q <= 1'b1;
            div_wait_q <= 1'b1;
            div_num_q <= 96'h8000_0000_0000_0000;
            div_den_q <= root_q;
            div_bits_q <= 7'd96;
          end else if (div_done) begin
            c_q <= div_quot;
            div_wait_q <= 1'b0;
            i_q <= 2'd0;
            st_q <= StDivU;
          end
        end
        StDivU: begin
          if (!div_wait_q) begin
            div_start_q <= 1'b1;
            div_wait_q <= 1'b1;
            div_num_q <= 96'(mag_a) << 47;
            div_den_q <= root_q;
            div_bits_q <= 7'd96;
          end else if (div_done) begin
            u_q[i_q] <= a_sel[31] ? -$signed(div_quot) : $signed(div_quot);
            div_wait_q <= 1'b0;
            if (i_q == 2'd2) begin
              i_q <= 2'd0;
              j_q <= 2'd0;
              st_q <= StMul;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
        end
        StMul: begin
          prod_q <= $signed(u_q[i_q][31:0]) * $signed(u_q[j_q][31:0]);
          st_q <= StDivT;
        end
        StDivT: begin
          if (!div_wait_q) begin
            div_start_q <= 1'b1;
            div_wait_q <= 1'b1;
            div_num_q <= {32'd0, pmag + ((64'(OneQ30) + c_q) >> 1)};
            div_den_q <= 64'(OneQ30) + c_q;
            div_bits_q <= 7'd65;
          end else if (div_done) begin
            t_q[i_q][j_q] <= prod_q[63] ? -$signed(div_floor) : $signed(div_floor);
            div_wait_q <= 1'b0;
            st_q <= StWait;
          end
        end
        StWait: begin
          if (j_q == 2'd2) begin
            j_q <= 2'd0;
            if (i_q == 2'd2) begin
              st_q <= StOut;
            end else begin
              i_q <= i_q + 2'd1;
              st_q <= StMul;
            end
          end else begin
            j_q <= j_q + 2'd1;
            st_q <= StMul;
          end
        end
        StOut: begin
          mat_q[0] <= sat32(c_q + t_q[0][0]);
          mat_q[1] <= sat32(-u_q[2] + t_q[0][1]);
          mat_q[2] <= sat32(u_q[1] + t_q[0][2]);
          mat_q[3] <= sat32(u_q[2] + t_q[1][0]);
          mat_q[4] <= sat32(c_q + t_q[1][1]);
          mat_q[5] <= sat32(-u_q[0] + t_q[1][2]);
          mat_q[6] <= sat32(-u_q[1] + t_q[2][0]);
          mat_q[7] <= sat32(u_q[0] + t_q[2][1]);
          mat_q[8] <= sat32(c_q + t_q[2][2]);
          st_q <= start_i ? StSum : StIdle;
          s_q <= 64'h1_0000_0000;
          i_q <= 2'd0;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy = (st_q != StIdle);
  assign mat_o = mat_q;
endmodule

// ===== src/rvpt_datapath.sv =====
// Four-stage pipeline that forms R*p + d for one point per cycle while the output is not stalled.
module rvpt_datapath
  import rvpt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic signed [DataW-1:0] px_i,
  input  logic signed [DataW-1:0] py_i,
  input  logic signed [DataW-1:0] pz_i,
  input  mat_t                    mat_i,
  input  logic [DataW-1:0]        shift_i [3],
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [DataW-1:0]        mx_o,
  output logic [DataW-1:0]        my_o,
  output logic [DataW-1:0]        mz_o,
  output logic                    idle_o
);
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv;
  logic signed [DataW-1:0] p1_q [3];
  logic signed [63:0] pr_q [9];
  logic [63:0] s_q [3];
  logic [DataW-1:0] o_q [3];

  assign adv = !(v4_q && stall_i);
  assign stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q[0] <= px_i;
      p1_q[1] <= py_i;
      p1_q[2] <= pz_i;
      for (int k = 0; k < 9; k++) begin
        pr_q[k] <= 64'(mat_i[k]) * 64'(p1_q[k % 3]);
      end
      for (int r = 0; r < 3; r++) begin
        s_q[r] <= 64'h2000_0000 + pr_q[3*r] + pr_q[3*r+1] + pr_q[3*r+2];
      end
      for (int r = 0; r < 3; r++) begin
        o_q[r] <= s_q[r][61:30] + shift_i[r];
      end
    end
  end

  assign valid_o = v4_q;
  assign mx_o = o_q[0];
  assign my_o = o_q[1];
  assign mz_o = o_q[2];
  assign idle_o = !(v1_q || v2_q || v3_q || v4_q);
endmodule

// ===== src/rotation_vector_point_transform_unit.sv =====
// Top level of the rotation-vector rigid point transform.
// Points enter on the in channel (in_valid_i, in_stall_o, point_*_i) and a
// transaction completes when valid is high and stall is low. Moved points
// leave on the out channel (out_valid_o, out_stall_i, moved_*_o).
// One point is taken every cycle while nothing stalls; the four-stage multiply
// and add pipeline forms one 32x32 product per entry.
// The receiver's stall freezes the whole pipeline, so nothing is lost.
// Configuration writes (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// are taken only while no rebuild runs and the pipeline is empty. A write of
// a register starts a matrix rebuild by a shared bit-serial divider and
// square-root sequencer; no point is taken until it is done.
// After reset the translation is zero and the matrix is the identity.
module rotation_vector_point_transform_unit
  import rvpt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] point_x_i,
  input  logic signed [DataW-1:0] point_y_i,
  input  logic signed [DataW-1:0] point_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] moved_x_o,
  output logic signed [DataW-1:0] moved_y_o,
  output logic signed [DataW-1:0] moved_z_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [DataW-1:0]        cfg_data_i
);
  logic [DataW-1:0] regs_q [6];
  logic       wr;
  logic       dp_stall, dp_valid, dp_idle;
  setup_ctl_t ctl;
  mat_t       mat;
  logic [DataW-1:0] shift [3];
  logic [DataW-1:0] mx, my, mz;

  assign cfg_ready_o = !ctl.busy && dp_idle;
  assign wr = cfg_valid_i && cfg_ready_o && (cfg_index_i <= RegRotZ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        regs_q[k] <= '0;
      end
    end else if (wr) begin
      regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  rvpt_setup u_setup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(wr),
    .rot_x_i(regs_q[RegRotX]),
    .rot_y_i(regs_q[RegRotY]),
    .rot_z_i(regs_q[RegRotZ]),
    .ctl_o  (ctl),
    .mat_o  (mat)
  );

  assign shift[0] = regs_q[RegShiftX];
  assign shift[1] = regs_q[RegShiftY];
  assign shift[2] = regs_q[RegShiftZ];

  rvpt_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i && !ctl.busy && !ctl.start),
    .stall_o(dp_stall),
    .px_i   (point_x_i),
    .py_i   (point_y_i),
    .pz_i   (point_z_i),
    .mat_i  (mat),
    .shift_i(shift),
    .valid_o(dp_valid),
    .stall_i(out_stall_i),
    .mx_o   (mx),
    .my_o   (my),
    .mz_o   (mz),
    .idle_o (dp_idle)
  );

  assign in_stall_o = dp_stall || ctl.busy || ctl.start;
  assign out_valid_o = dp_valid;
  assign moved_x_o = mx;
  assign moved_y_o = my;
  assign moved_z_o = mz;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(moved_x_o))
    else $error("stalled result changed");
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.busy |-> in_stall_o)
    else $error("point accepted during rebuild");
endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the rotation-vector rigid point transform unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rvpt_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DataW-1:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DataW-1:0] moved_x_o, moved_y_o, moved_z_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
  } vec_t;

  vec_t pending_points[$];
  vec_t expected_moves[$];
  logic signed [MatW-1:0] rot_mat [NumEntries];
  logic signed [DataW-1:0] xlate [3];
  logic signed [DataW-1:0] rot_vec [3];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_off = 0;
  bit in_taken = 1'b0;
  bit cfg_done;

  rotation_vector_point_transform_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [63:0] mag_of(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] round_div(logic [63:0] num, logic [63:0] den, int fb);
    logic [63:0] quo, rem;
    quo = num / den;
    rem = num % den;
    for (int i = 0; i < fb + 1; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return (quo + 1) >> 1;
  endfunction

  function automatic logic signed [MatW-1:0] clamp32(logic signed [63:0] v);
    if (v > 64'sh7fffffff) return 32'sh7fffffff;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void build_rotation();
    logic [63:0] sum_sq, root, rem, trial, pair, den, m;
    logic signed [63:0] c, prod;
    logic signed [63:0] u [3];
    logic signed [63:0] t [3][3];
    sum_sq = 64'd1 << 32;
    for (int i = 0; i < 3; i++) begin
      m = mag_of(64'(rot_vec[i]));
      sum_sq += m * m;
    end
    root = 0;
    rem = 0;
    for (int i = 47; i >= 0; i--) begin
      pair = (i >= 16) ? ((sum_sq >> (2 * (i - 16))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    c = round_div(64'd1 << 32, root, 30);
    for (int i = 0; i < 3; i++) begin
      m = round_div(mag_of(64'(rot_vec[i])) << 16, root, 30);
      u[i] = rot_vec[i] < 0 ? -$signed(m) : $signed(m);
    end
    den = (64'd1 << 30) + c;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod = u[i] * u[j];
        m = (mag_of(prod) + den / 2) / den;
        t[i][j] = prod < 0 ? -$signed(m) : $signed(m);
      end
    end
    rot_mat[0] = clamp32(c + t[0][0]);
    rot_mat[1] = clamp32(-u[2] + t[0][1]);
    rot_mat[2] = clamp32(u[1] + t[0][2]);
    rot_mat[3] = clamp32(u[2] + t[1][0]);
    rot_mat[4] = clamp32(c + t[1][1]);
    rot_mat[5] = clamp32(-u[0] + t[1][2]);
    rot_mat[6] = clamp32(-u[1] + t[2][0]);
    rot_mat[7] = clamp32(u[0] + t[2][1]);
    rot_mat[8] = clamp32(c + t[2][2]);
  endfunction

  function automatic vec_t move_point(vec_t p);
    logic [63:0] acc;
    logic signed [63:0] pv [3];
    logic [31:0] res [3];
    vec_t r;
    pv[0] = p.x;
    pv[1] = p.y;
    pv[2] = p.z;
    for (int row = 0; row < 3; row++) begin
      acc = 64'd1 << 29;
      for (int j = 0; j < 3; j++) acc += 64'(64'(rot_mat[row * 3 + j]) * pv[j]);
      res[row] = acc[61:30] + xlate[row];
    end
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    cfg_done = 0;
    while (!cfg_done) begin
      cfg_done = cfg_ready_o;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx < 3) xlate[idx] = val;
    else if (idx < 6) begin
      rot_vec[idx - 3] = val;
      build_rotation();
    end
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || expected_moves.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 65536 * 4) - 131072;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vec_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points.push_back(p);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // The driver predicts at acceptance, so the matrix in force is the current one.
  always @(posedge clk_i) begin
    vec_t cur;
    in_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      cur.x = point_x_i;
      cur.y = point_y_i;
      cur.z = point_z_i;
      expected_moves.push_back(move_point(cur));
      void'(pending_points.pop_front());
      send_wait <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid_i <= 1'b0;
        end else if (pending_points.size() != 0) begin
          in_valid_i <= 1'b1;
          point_x_i <= pending_points[0].x;
          point_y_i <= pending_points[0].y;
          point_z_i <= pending_points[0].z;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    vec_t exp_v;
    if (out_valid_o && !out_stall_i) begin
      if (expected_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h", moved_x_o, moved_y_o,
                                       moved_z_o);
      end else begin
        exp_v = expected_moves.pop_front();
        if (moved_x_o !== exp_v.x || moved_y_o !== exp_v.y || moved_z_o !== exp_v.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("moved point: expected %h %h %h, got %h %h %h", exp_v.x, exp_v.y,
                     exp_v.z, moved_x_o, moved_y_o, moved_z_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off != 0) hold_off <= hold_off - 1;
  end

  always @(negedge clk_i) begin
    if (hold_off != 0) begin
      out_stall_i <= 1'b1;
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (out_valid_o && !out_stall_i)
        recv_wait <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 0;
    end
  end

  initial begin
    logic [31:0] edge_vals [4];
    edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    for (int i = 0; i < 3; i++) begin
      xlate[i] = '0;
      rot_vec[i] = '0;
    end
    build_rotation();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed points under the identity: extremes and single bits.
    for (int i = 0; i < 4; i++) queue_point(edge_vals[i], edge_vals[(i + 1) % 4],
                                            edge_vals[(i + 2) % 4]);
    queue_point(32'h00010000, 32'hffff0000, 32'h00008000);
    queue_point(32'h55555555, 32'haaaaaaaa, 32'h12345678);
    drain();

    // Hold the output off so the pipeline fills and the input stalls.
    @(negedge clk_i);
    hold_off <= 200;
    for (int i = 0; i < 40; i++) queue_point($urandom, $urandom, $urandom);
    drain();

    // Full-range rotation vector and translation.
    for (int i = 0; i < 6; i++) write_reg(3'(i), 32'h7fffffff);
    for (int i = 0; i < 4; i++) queue_point(edge_vals[i], edge_vals[3 - i], 32'h00010000);
    drain();
    for (int i = 0; i < 6; i++) write_reg(3'(i), 32'h80000000);
    for (int i = 0; i < 4; i++) queue_point(edge_vals[i], edge_vals[3 - i], edge_vals[i]);
    drain();
    // Index past the register list must leave the transform untouched.
    write_reg(3'd6, 32'h12345678);
    write_reg(3'd7, 32'hdeadbeef);
    queue_point(32'h00010000, 32'h00020000, 32'h00030000);
    drain();
    // Back to zero rotation: identity again.
    write_reg(RegRotX, '0);
    write_reg(RegRotY, '0);
    write_reg(RegRotZ, '0);
    queue_point(32'h7fffffff, 32'h80000000, 32'h00010000);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      write_reg(RegShiftX, rand_word());
      write_reg(RegShiftY, rand_word());
      write_reg(RegShiftZ, rand_word());
      write_reg(RegRotX, rand_word());
      write_reg(RegRotY, rand_word());
      write_reg(RegRotZ, rand_word());
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 1)) queue_point(rand_word(), rand_word(), rand_word());
        else queue_point($urandom, $urandom, $urandom);
      end
      drain();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
